@@ design/lmtm_pkg.sv @@
// ----------------------------------------------------------------------------
// Low memory threshold monitor package
// Shared payload types, configuration types and register indexes.
// ----------------------------------------------------------------------------
package lmtm_pkg;

    localparam int unsigned CNT_W     = 32;  // width of an input page counter
    localparam int unsigned AVAIL_W   = 34;  // width of the available page estimate
    localparam int unsigned IDX_W     = 3;   // width of a threshold index
    localparam int unsigned NUM_THR   = 4;   // number of threshold registers
    localparam int unsigned THR_SEL_W = 2;   // bits that select a threshold register
    localparam int unsigned REG_IDX_W = 3;   // width of the register index

    localparam int unsigned DEF_THRESHOLD_SLOTS = 4;
    localparam int unsigned DEF_PAGE_SHIFT_BITS = 12;

    // Threshold index that means no threshold lies above the estimate.
    localparam logic [IDX_W-1:0] NO_INDEX = 3'd4;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWAP_WEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FILE_KB = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THR_COUNT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_3 = 3'd7;

    typedef struct packed {
        logic [CNT_W-1:0] free_pages;
        logic [CNT_W-1:0] reserve_pages;
        logic [CNT_W-1:0] active_file_pages;
        logic [CNT_W-1:0] inactive_file_pages;
        logic [CNT_W-1:0] dirty_file_pages;
        logic [CNT_W-1:0] active_anon_pages;
        logic [CNT_W-1:0] inactive_anon_pages;
        logic [CNT_W-1:0] swap_free_pages;
    } in_item_t;

    typedef struct packed {
        logic [AVAIL_W-1:0] available_pages;
        logic               low_memory;
        logic               entering_low;
        logic               threshold_crossed;
        logic [IDX_W-1:0]   threshold_index;
    } out_item_t;

    typedef struct packed {
        logic                          monitor_enable;
        logic [CNT_W-1:0]              swap_weight;
        logic [CNT_W-1:0]              min_file_pages;
        logic [IDX_W-1:0]              threshold_count;
        logic [NUM_THR-1:0][CNT_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ design/lmtm_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel interface
// Carries one snapshot of page counters per transaction.
// ----------------------------------------------------------------------------
interface lmtm_in_if;
    logic               valid;
    logic               ready;
    lmtm_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/lmtm_out_if.sv @@
// ----------------------------------------------------------------------------
// Output channel interface
// Carries one monitor result per transaction.
// ----------------------------------------------------------------------------
interface lmtm_out_if;
    logic                valid;
    logic                ready;
    lmtm_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/lmtm_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file; also converts the kept-back file size to pages.
// ----------------------------------------------------------------------------
module lmtm_regs #(
    parameter int unsigned PAGE_SHIFT_BITS = lmtm_pkg::DEF_PAGE_SHIFT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lmtm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [lmtm_pkg::CNT_W-1:0]          cfg_data,
    output lmtm_pkg::cfg_t                      cfg
);

    // 50 MB expressed in pages.
    localparam logic [lmtm_pkg::CNT_W-1:0] THR0_RESET =
        lmtm_pkg::CNT_W'((64'd50 * 64'd1024 * 64'd1024) >> PAGE_SHIFT_BITS);
    localparam int unsigned KB_SHIFT = PAGE_SHIFT_BITS - 10;

    logic                                                 enable_reg;
    logic [lmtm_pkg::CNT_W-1:0]                           weight_reg;
    logic [lmtm_pkg::CNT_W-1:0]                           min_kb_reg;
    logic [lmtm_pkg::IDX_W-1:0]                           count_reg;
    logic [lmtm_pkg::NUM_THR-1:0][lmtm_pkg::CNT_W-1:0]    thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            weight_reg <= lmtm_pkg::CNT_W'(4);
            min_kb_reg <= '0;
            count_reg  <= lmtm_pkg::IDX_W'(1);
            thr_reg[0] <= THR0_RESET;
            thr_reg[1] <= '0;
            thr_reg[2] <= '0;
            thr_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmtm_pkg::REG_ENABLE:      enable_reg <= cfg_data[0];
                lmtm_pkg::REG_SWAP_WEIGHT: weight_reg <= cfg_data;
                lmtm_pkg::REG_MIN_FILE_KB: min_kb_reg <= cfg_data;
                lmtm_pkg::REG_THR_COUNT:   count_reg  <= cfg_data[lmtm_pkg::IDX_W-1:0];
                lmtm_pkg::REG_THRESHOLD_0: thr_reg[0] <= cfg_data;
                lmtm_pkg::REG_THRESHOLD_1: thr_reg[1] <= cfg_data;
                lmtm_pkg::REG_THRESHOLD_2: thr_reg[2] <= cfg_data;
                lmtm_pkg::REG_THRESHOLD_3: thr_reg[3] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        cfg.monitor_enable  = enable_reg;
        cfg.swap_weight     = weight_reg;
        cfg.min_file_pages  = min_kb_reg >> KB_SHIFT;
        cfg.threshold_count = count_reg;
        cfg.threshold       = thr_reg;
    end

endmodule

@@ design/lmtm_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmtm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  lmtm_pkg::div_req_t req,
    output lmtm_pkg::div_rsp_t rsp
);

    localparam int unsigned W     = lmtm_pkg::CNT_W;
    localparam int unsigned STEPW = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [STEPW-1:0] step_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]       trial;
    logic [W:0]       diff;

    // Shift the next dividend bit into the remainder and try the subtraction.
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // Done pulses for one cycle after the last quotient bit.
            done_reg <= busy_reg && !req.start && (step_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEPW'(W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEPW'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ design/lmtm_core.sv @@
// ----------------------------------------------------------------------------
// Monitor sequencer
// Steps one snapshot through the estimate, the swap divide and the threshold scan.
// ----------------------------------------------------------------------------
module lmtm_core #(
    parameter int unsigned THRESHOLD_SLOTS = lmtm_pkg::DEF_THRESHOLD_SLOTS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lmtm_pkg::cfg_t cfg,
    lmtm_in_if.sink        in_ch,
    lmtm_out_if.source     out_ch
);

    localparam int unsigned CW = lmtm_pkg::CNT_W;
    localparam int unsigned AW = lmtm_pkg::AVAIL_W;
    localparam int unsigned IW = lmtm_pkg::IDX_W;
    // Largest usable threshold count.
    localparam int unsigned CLAMP = (THRESHOLD_SLOTS < lmtm_pkg::NUM_THR) ?
                                    THRESHOLD_SLOTS : lmtm_pkg::NUM_THR;
    localparam logic [IW-1:0] CLAMP_CNT = IW'(CLAMP);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SUM1 = 8'b00000010,
        S_SUM2 = 8'b00000100,
        S_SUM3 = 8'b00001000,
        S_SUM4 = 8'b00010000,
        S_DIV  = 8'b00100000,
        S_SCAN = 8'b01000000,
        S_DONE = 8'b10000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;

    lmtm_pkg::in_item_t  item_reg;
    logic [CW:0]         file_reg;
    logic [CW:0]         anon_reg;
    logic [CW-1:0]       swap_reg;
    logic [CW:0]         fnet_reg;
    logic [CW-1:0]       free_net_reg;
    logic [AW-1:0]       avail_reg;
    logic [IW-1:0]       scan_reg;

    logic                was_low_reg;
    logic [IW-1:0]       last_idx_reg;
    lmtm_pkg::out_item_t result_reg;

    lmtm_pkg::div_req_t  div_req;
    lmtm_pkg::div_rsp_t  div_rsp;

    logic [IW-1:0]       count_eff;
    logic                in_range;
    logic                hit;
    logic                finish;
    logic [IW-1:0]       idx_found;
    logic                low_now;

    lmtm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_req.start    = (state_reg == S_SUM4) && (cfg.swap_weight != '0);
        div_req.dividend = swap_reg;
        div_req.divisor  = cfg.swap_weight;
    end

    // Threshold scan: one compare per cycle against the selected register.
    always_comb
    begin
        count_eff = (cfg.threshold_count > CLAMP_CNT) ? CLAMP_CNT : cfg.threshold_count;
        in_range  = scan_reg < count_eff;
        hit       = in_range &&
                    (avail_reg < {2'b00, cfg.threshold[scan_reg[lmtm_pkg::THR_SEL_W-1:0]]});
        finish    = !in_range || hit;
        idx_found = hit ? scan_reg : lmtm_pkg::NO_INDEX;
        low_now   = avail_reg < {2'b00, cfg.threshold[0]};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = S_SUM1;
            S_SUM1:  state_next = S_SUM2;
            S_SUM2:  state_next = S_SUM3;
            S_SUM3:  state_next = S_SUM4;
            S_SUM4:  state_next = (cfg.swap_weight != '0) ? S_DIV : S_SCAN;
            S_DIV:   if (div_rsp.done) state_next = S_SCAN;
            S_SCAN:  if (!cfg.monitor_enable || finish) state_next = S_DONE;
            S_DONE:  if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            was_low_reg  <= 1'b0;
            last_idx_reg <= lmtm_pkg::NO_INDEX;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_SCAN) && cfg.monitor_enable && finish)
            begin
                was_low_reg  <= low_now;
                last_idx_reg <= idx_found;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= in_ch.data;
            end
            S_SUM1:
            begin
                file_reg <= {1'b0, item_reg.active_file_pages}
                          + {1'b0, item_reg.inactive_file_pages};
                anon_reg <= {1'b0, item_reg.active_anon_pages}
                          + {1'b0, item_reg.inactive_anon_pages};
            end
            S_SUM2:
            begin
                fnet_reg     <= (file_reg > {1'b0, item_reg.dirty_file_pages}) ?
                                file_reg - {1'b0, item_reg.dirty_file_pages} : '0;
                free_net_reg <= (item_reg.free_pages > item_reg.reserve_pages) ?
                                item_reg.free_pages - item_reg.reserve_pages : '0;
                swap_reg     <= ({1'b0, item_reg.swap_free_pages} < anon_reg) ?
                                item_reg.swap_free_pages : anon_reg[CW-1:0];
            end
            S_SUM3:
            begin
                fnet_reg <= (fnet_reg > {1'b0, cfg.min_file_pages}) ?
                            fnet_reg - {1'b0, cfg.min_file_pages} : '0;
            end
            S_SUM4:
            begin
                avail_reg <= {2'b00, free_net_reg} + {1'b0, fnet_reg};
                scan_reg  <= '0;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    avail_reg <= avail_reg + {2'b00, div_rsp.quotient};
                end
            end
            S_SCAN:
            begin
                if (!cfg.monitor_enable)
                begin
                    result_reg.available_pages   <= avail_reg;
                    result_reg.low_memory        <= 1'b0;
                    result_reg.entering_low      <= 1'b0;
                    result_reg.threshold_crossed <= 1'b0;
                    result_reg.threshold_index   <= lmtm_pkg::NO_INDEX;
                end
                else if (finish)
                begin
                    result_reg.available_pages   <= avail_reg;
                    result_reg.low_memory        <= low_now;
                    result_reg.entering_low      <= low_now && !was_low_reg;
                    result_reg.threshold_crossed <= idx_found < last_idx_reg;
                    result_reg.threshold_index   <= idx_found;
                end
                else
                begin
                    scan_reg <= scan_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_DONE);
    assign out_ch.data  = result_reg;

endmodule

@@ design/low_memory_threshold_monitor.sv @@
// ----------------------------------------------------------------------------
// Low memory threshold monitor
// Estimates available pages from a counter snapshot and flags low memory and
// threshold crossings.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake          Payload
//   in_ch     sink        valid / ready      eight 32-bit page counters
//   out_ch    source      valid / ready      estimate, flags, threshold index
//   cfg       write only  cfg_we             cfg_index (3 bits), cfg_data (32 bits)
//
// One transaction passes through the estimate arithmetic (states SUM1 to
// SUM4), the serial divider when the swap weight is nonzero, and the
// threshold scan, which compares one threshold per step and takes a last
// step when none in use lies above the estimate. The block does not take a
// new transaction before it is through with the last: it holds in_ch.ready
// low from acceptance until the result has been taken on out_ch.
// A stalled out_ch simply holds the result and keeps the input closed.
// Reset restores the register defaults and clears the low flag history.
//
// The estimate is free pages less reserve (floored at zero), plus clean file
// pages above the kept-back minimum (floored at zero), plus the smaller of
// free swap and anonymous pages divided by the swap weight. A weight of zero
// leaves the swap share out and skips the divider entirely.
//
// The threshold scan walks the thresholds in use one per cycle through a
// single comparator and stops at the first one above the estimate. The low
// flag and the scan result update the history only while the monitor is
// enabled; when it is disabled the flags read zero and the index reads "none".
// ----------------------------------------------------------------------------
module low_memory_threshold_monitor #(
    parameter int unsigned THRESHOLD_SLOTS = lmtm_pkg::DEF_THRESHOLD_SLOTS,
    parameter int unsigned PAGE_SHIFT_BITS = lmtm_pkg::DEF_PAGE_SHIFT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lmtm_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [lmtm_pkg::CNT_W-1:0]     cfg_data,
    lmtm_in_if.sink                        in_ch,
    lmtm_out_if.source                     out_ch
);

    // Register file contents, already converted to the units the core needs.
    lmtm_pkg::cfg_t cfg;

    lmtm_regs #(
        .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The core owns both channels and the serial divider.
    lmtm_core #(
        .THRESHOLD_SLOTS (THRESHOLD_SLOTS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
